### sv/base64_stream_decoder_core_defines.svh
// assertion helpers shared by the decoder rtl
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define B64SD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/b64sd_pkg.sv
package b64sd_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_BAD_LEN  = 2'd2,
		ST_BAD_PAD  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_DATA,
		CLS_PAD,
		CLS_BAD
	} cls_kind_t;

	typedef struct packed {
		cls_kind_t  kind;
		logic [5:0] val;
	} cls_t;

	// one queued group: up to three bytes sharing end and status flags
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  last_idx;
		logic        last;
		status_t     status;
	} grp_t;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r.kind = CLS_BAD;
		r.val  = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.kind = CLS_DATA;
			r.val  = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.kind = CLS_DATA;
			r.val  = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.kind = CLS_DATA;
			r.val  = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.kind = CLS_DATA;
			r.val  = 6'd62;
		end else if (c == 8'h2F) begin
			r.kind = CLS_DATA;
			r.val  = 6'd63;
		end else if (c == PAD_CHAR) begin
			r.kind = CLS_PAD;
		end
		return r;
	endfunction

endpackage

### sv/base64_stream_decoder_core.sv
// Streaming Base64 decoder (standard alphabet). One character is taken per
// transaction and one decoded byte leaves per transaction; the input side
// accepts a character every cycle while the result queue (QDEPTH group
// entries) has room, so sustained input rate is one character per clock and
// a group's first byte is queued as its fourth character is taken. A complete
// group is one queue entry, drained one byte per cycle while out_stall is low,
// so the byte drain (three bytes per four characters) keeps up with the input.
// Faults (bad character, misplaced '=', length not a multiple of four) are
// sticky per string: later characters are swallowed and the string ends with a
// single transaction carrying out_byte 0, is_last 1 and the error status; bytes
// already delivered for that string must be dropped by the consumer. All state
// returns to idle after every end_of_text character.
`include "base64_stream_decoder_core_defines.svh"

module base64_stream_decoder_core #(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_last,
	output logic [1:0] status
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	// per-string decode state
	logic [17:0]        acc_q;
	logic [1:0]         pos_q;
	logic [1:0]         pad_q;
	b64sd_pkg::status_t err_q;

	// group queue
	b64sd_pkg::grp_t    q_mem [QDEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic [1:0]         idx_q;

	logic               in_acc;
	logic               out_acc;
	logic               push;
	logic               pop;
	b64sd_pkg::grp_t    head;

	// next-state of the decoder
	b64sd_pkg::cls_t    cls;
	b64sd_pkg::status_t err_c;
	b64sd_pkg::status_t e;
	logic [17:0]        acc_c;
	logic [1:0]         pos_c;
	logic [1:0]         pad_c;
	logic [1:0]         pad_inc;
	logic [5:0]         v;
	logic               push_c;
	b64sd_pkg::grp_t    ent_c;

	assign in_stall  = (cnt_q == CW'(QDEPTH));
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (cnt_q != '0);
	assign out_acc   = out_valid && !out_stall;
	assign head      = q_mem[rd_ptr_q];
	assign pop       = out_acc && (idx_q == head.last_idx);
	assign push      = in_acc && push_c;

	always_comb begin
		cls     = b64sd_pkg::classify(char_code);
		err_c   = err_q;
		acc_c   = acc_q;
		pos_c   = pos_q;
		pad_c   = pad_q;
		pad_inc = pad_q;
		v       = cls.val;
		e       = b64sd_pkg::ST_OK;
		push_c  = 1'b0;
		ent_c   = '{word: {acc_q, cls.val}, last_idx: 2'd2, last: end_of_text,
			status: b64sd_pkg::ST_OK};

		if (err_q == b64sd_pkg::ST_OK) begin
			// character check
			if (cls.kind == b64sd_pkg::CLS_BAD) begin
				e = b64sd_pkg::ST_BAD_CHAR;
			end else if (cls.kind == b64sd_pkg::CLS_PAD) begin
				if (pos_q < 2'd2) begin
					e = b64sd_pkg::ST_BAD_PAD;
				end else begin
					pad_inc = pad_q + 2'd1;
					v       = 6'd0;
				end
			end else if (pad_q != 2'd0) begin
				// data after a pad in the same group
				e = b64sd_pkg::ST_BAD_PAD;
			end

			if (e == b64sd_pkg::ST_OK) begin
				if (pos_q != 2'd3) begin
					acc_c = {acc_q[11:0], v};
					pos_c = pos_q + 2'd1;
					pad_c = pad_inc;
				end else begin
					// group complete; a padded group must end the string
					if (pad_inc != 2'd0 && !end_of_text) begin
						e = b64sd_pkg::ST_BAD_PAD;
					end else begin
						push_c         = 1'b1;
						ent_c.word     = {acc_q, v};
						ent_c.last_idx = 2'd2 - pad_inc;
					end
					acc_c = '0;
					pos_c = 2'd0;
					pad_c = 2'd0;
				end
			end

			if (end_of_text && e == b64sd_pkg::ST_OK && pos_c != 2'd0) begin
				e = b64sd_pkg::ST_BAD_LEN;
			end
			err_c = e;
		end

		if (end_of_text) begin
			// error report replaces any bytes of this character
			if (err_c != b64sd_pkg::ST_OK) begin
				push_c = 1'b1;
				ent_c  = '{word: 24'd0, last_idx: 2'd0, last: 1'b1, status: err_c};
			end
			acc_c = '0;
			pos_c = 2'd0;
			pad_c = 2'd0;
			err_c = b64sd_pkg::ST_OK;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= 2'd0;
			pad_q <= 2'd0;
			err_q <= b64sd_pkg::ST_OK;
		end else if (in_acc) begin
			acc_q <= acc_c;
			pos_q <= pos_c;
			pad_q <= pad_c;
			err_q <= err_c;
		end
	end

	// queue storage, payload only
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= ent_c;
		end
	end

	// queue pointers and byte index within the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				idx_q    <= 2'd0;
			end else if (out_acc) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	// byte select out of the head group
	always_comb begin
		case (idx_q)
			2'd0:    out_byte = head.word[23:16];
			2'd1:    out_byte = head.word[15:8];
			default: out_byte = head.word[7:0];
		endcase
	end

	assign is_last = head.last && (idx_q == head.last_idx);
	assign status  = head.status;

	`B64SD_ASSERT_NOW(a_err_report, out_valid && status != b64sd_pkg::ST_OK, out_byte == 8'd0 && is_last, "error transaction must be a zero final byte")
	`B64SD_ASSERT_NEXT(a_eot_clears, in_acc && end_of_text, pos_q == 2'd0 && pad_q == 2'd0 && err_q == b64sd_pkg::ST_OK, "state not cleared after end of text")
	`B64SD_ASSERT_NOW(a_pad_pos, pad_q != 2'd0, pos_q == 2'd3, "pad count set outside last group slot")
	`B64SD_ASSERT_NOW(a_idx_range, out_valid, idx_q <= head.last_idx, "byte index beyond head group")

endmodule
